### design/pbic_pkg.sv
// Shared types and constants for the banded-integral PID controller.
// Used by the config registers, the serial arithmetic units, the top level and the checker.
package pbic_pkg;

  localparam int LIMIT_WHOLE = 127;
  localparam int MS_PER_S    = 1000;

  localparam int DATA_W     = 32;
  localparam int MS_W       = 16;
  localparam int GAIN_W     = 32;
  localparam int BAND_W     = 31;
  localparam int DRIVE_W    = 24;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // serial multiplier: 48-bit multiplicand, 32-bit multiplier
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  // serial divider: 48-bit dividend, 16-bit divisor
  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 16;
  localparam int CNT_W   = 6;

  localparam int SUM_W = 48;
  localparam int ACC_W = 82;

  localparam int DRIVE_LIM = LIMIT_WHOLE << FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_BAND_LOW,
    REG_BAND_HIGH,
    REG_GATE_NEAR,
    REG_GATE_FAR
  } pbic_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ABS,
    ST_FLAGS,
    ST_I_MUL,
    ST_I_DIV,
    ST_I_UPD,
    ST_D_MUL,
    ST_D_DIV,
    ST_P_MUL,
    ST_G_MUL,
    ST_K_MUL,
    ST_OUT
  } pbic_state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measured;
    logic [MS_W-1:0]          elapsed_ms;
  } pbic_in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
  } pbic_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [BAND_W-1:0] band_low;
    logic [BAND_W-1:0] band_high;
    logic [BAND_W-1:0] gate_near;
    logic [BAND_W-1:0] gate_far;
  } pbic_cfg_t;

  // start command for a serial unit
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] cycles;
  } pbic_cmd_t;

endpackage

### design/pbic_cfg_regs.sv
// Configuration register file: gains, integral bands and derivative gates.
// Depends on pbic_pkg for the register index codes and the config struct.
module pbic_cfg_regs
  import pbic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wen,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output pbic_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wen) begin
      case (index)
        REG_GAIN_P:    cfg.gain_p    <= data[GAIN_W-1:0];
        REG_GAIN_I:    cfg.gain_i    <= data[GAIN_W-1:0];
        REG_GAIN_D:    cfg.gain_d    <= data[GAIN_W-1:0];
        REG_BAND_LOW:  cfg.band_low  <= data[BAND_W-1:0];
        REG_BAND_HIGH: cfg.band_high <= data[BAND_W-1:0];
        REG_GATE_NEAR: cfg.gate_near <= data[BAND_W-1:0];
        REG_GATE_FAR:  cfg.gate_far  <= data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### design/pbic_serial_mul.sv
// Serial-parallel multiplier: one multiplier bit per cycle, shift-right product.
// After a run of N multiplier bits the product sits at prod shifted left by (MUL_B_W - N). Uses pbic_pkg.
module pbic_serial_mul
  import pbic_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  pbic_cmd_t          cmd,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [PROD_W-1:0]  prod
);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_A_W-1:0] mcand;
  logic [MUL_A_W-1:0] hi;
  logic [MUL_B_W-1:0] lo;
  logic [MUL_A_W:0]   psum;

  assign psum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.cycles;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= psum[MUL_A_W:1];
      lo <= {psum[0], lo[MUL_B_W-1:1]};
    end
  end

endmodule

### design/pbic_serial_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Dividend is loaded MSB-aligned; after N quotient bits quot holds the quotient. Uses pbic_pkg.
module pbic_serial_div
  import pbic_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  pbic_cmd_t          cmd,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quot
);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W-1:0] dvs;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   tdiff;
  logic               ge;

  assign trial = {rem, quot[DIV_N_W-1]};
  assign tdiff = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.cycles;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so it fits DIV_D_W bits
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvs  <= divisor;
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      rem  <= ge ? tdiff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quot <= {quot[DIV_N_W-2:0], ge};
    end
  end

endmodule

### design/pid_banded_integral_controller_top.sv
// Top level of the banded-integral PID controller: sequencer and datapath.
// Depends on pbic_pkg, pbic_cfg_regs, pbic_serial_mul and pbic_serial_div.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  in_data  (target, measured, elapsed_ms)
//   out      source     out_valid / out_stall out_data (drive, clamped)
//   cfg      sink       cfg_wen              cfg_index, cfg_data
//
// One transaction at a time. The work runs on the serial multiplier (16, 10 and 3 x 32 bit
// steps) and the restoring divider (48 and 42 bit steps); integral and derivative work is
// skipped when not needed.
// The next input can be taken in the cycle after the result is registered.
// A waiting result does not block input; stall on out holds the block only at the end.
// rst is synchronous and clears the integral, the previous samples and the config.
module pid_banded_integral_controller_top
  import pbic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pbic_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pbic_out_t             out_data,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int I_MUL_CYCLES = MS_W;
  localparam int D_MUL_CYCLES = 10;
  localparam int G_MUL_CYCLES = GAIN_W;
  localparam int I_DIV_CYCLES = DIV_N_W;
  localparam int D_DIV_CYCLES = 42;

  localparam logic signed [ACC_W-1:0] ACC_LIM     = ACC_W'(LIMIT_WHOLE) << (2 * FRAC_W);
  localparam logic signed [ACC_W-1:0] ACC_LIM_NEG = -ACC_LIM;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(DRIVE_LIM);
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  pbic_state_e state, state_next;
  pbic_cfg_t   cfg;
  pbic_in_t    in_q;

  logic [DATA_W:0]   err, diff;
  logic [DATA_W:0]   err_abs, diff_abs;
  logic [DATA_W-1:0] tgt_abs;
  logic [DATA_W-1:0] aerr, diff_mag, tgt_mag;
  logic [DATA_W-1:0] prev_target, prev_meas;
  logic [SUM_W-1:0]  integral, integ_mag, integ_sat;
  logic [SUM_W+1:0]  sum_ext;
  logic              deriv_go;

  logic signed [ACC_W-1:0] acc, acc_next, acc_base;
  logic                    acc_neg;

  pbic_cmd_t          mul_cmd, div_cmd;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [PROD_W-1:0]  mul_prod;
  logic [DIV_N_W-1:0] div_dividend, div_quot;
  logic [DIV_D_W-1:0] div_divisor;
  logic               div_done;

  logic      in_accept, ms_nz;
  logic      integ_en_c, band_clear_c, use_d_c, integ_go_c, deriv_now_c;
  logic      clamp_pos, clamp_neg, out_free;
  pbic_out_t out_result;

  pbic_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wen   (cfg_wen),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  pbic_serial_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mul_cmd),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  pbic_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign ms_nz     = (in_q.elapsed_ms != '0);
  assign out_free  = !out_valid || !out_stall;

  // magnitudes
  assign err_abs  = err[DATA_W] ? -err : err;
  assign diff_abs = diff[DATA_W] ? -diff : diff;
  assign tgt_abs  = in_q.target[DATA_W-1] ? -in_q.target : in_q.target;
  assign integ_mag = integral[SUM_W-1] ? -integral : integral;

  // band and gate decisions, all on |error|
  assign integ_en_c   = (aerr > {1'b0, cfg.band_low}) && (aerr < {1'b0, cfg.band_high});
  assign band_clear_c = (aerr > {1'b0, cfg.band_high});
  assign use_d_c      = ((tgt_mag > aerr) && (aerr < {1'b0, cfg.gate_near})) ||
                        ((tgt_mag < aerr) && (aerr < {1'b0, cfg.gate_far}));
  assign integ_go_c   = integ_en_c && ms_nz;
  assign deriv_now_c  = use_d_c && ms_nz;

  // integral + signed increment, saturated to SUM_W bits
  assign sum_ext = {{2{integral[SUM_W-1]}}, integral} +
                   ((SUM_W+2)'(div_quot) ^ {(SUM_W+2){err[DATA_W]}}) +
                   (SUM_W+2)'(err[DATA_W]);

  always_comb begin
    if (sum_ext[SUM_W+1 -: 3] == 3'b000 || sum_ext[SUM_W+1 -: 3] == 3'b111) begin
      integ_sat = sum_ext[SUM_W-1:0];
    end else begin
      integ_sat = sum_ext[SUM_W+1] ? SUM_MIN : SUM_MAX;
    end
  end

  // product sign per term; the derivative term is subtracted
  always_comb begin
    case (state)
      ST_P_MUL: acc_neg = err[DATA_W];
      ST_G_MUL: acc_neg = integral[SUM_W-1];
      ST_K_MUL: acc_neg = !diff[DATA_W];
      default:  acc_neg = 1'b0;
    endcase
  end

  assign acc_base = (state == ST_P_MUL) ? '0 : acc;
  assign acc_next = acc_base + (ACC_W'(mul_prod) ^ {ACC_W{acc_neg}}) + ACC_W'(acc_neg);

  assign clamp_pos = (acc > ACC_LIM);
  assign clamp_neg = (acc < ACC_LIM_NEG);

  always_comb begin
    out_result.clamped = clamp_pos || clamp_neg;
    if (clamp_pos) begin
      out_result.drive = DRIVE_MAX;
    end else if (clamp_neg) begin
      out_result.drive = -DRIVE_MAX;
    end else begin
      out_result.drive = acc[FRAC_W+DRIVE_W-1:FRAC_W];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_accept) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_ABS;
      ST_ABS:   state_next = ST_FLAGS;
      ST_FLAGS: begin
        if (integ_go_c) begin
          state_next = ST_I_MUL;
        end else if (deriv_now_c) begin
          state_next = ST_D_MUL;
        end else begin
          state_next = ST_P_MUL;
        end
      end
      ST_I_MUL: if (mul_done) state_next = ST_I_DIV;
      ST_I_DIV: if (div_done) state_next = ST_I_UPD;
      ST_I_UPD: state_next = deriv_go ? ST_D_MUL : ST_P_MUL;
      ST_D_MUL: if (mul_done) state_next = ST_D_DIV;
      ST_D_DIV: if (div_done) state_next = ST_P_MUL;
      ST_P_MUL: if (mul_done) state_next = ST_G_MUL;
      ST_G_MUL: if (mul_done) state_next = deriv_go ? ST_K_MUL : ST_OUT;
      ST_K_MUL: if (mul_done) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // unit commands: each start loads operands into the unit
  always_comb begin
    mul_cmd      = '0;
    mul_a        = '0;
    mul_b        = '0;
    div_cmd      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      ST_FLAGS: begin
        mul_cmd.start = 1'b1;
        if (integ_go_c) begin
          mul_cmd.cycles = CNT_W'(I_MUL_CYCLES);
          mul_a          = MUL_A_W'(aerr);
          mul_b          = MUL_B_W'(in_q.elapsed_ms);
        end else if (deriv_now_c) begin
          mul_cmd.cycles = CNT_W'(D_MUL_CYCLES);
          mul_a          = MUL_A_W'(diff_mag);
          mul_b          = MUL_B_W'(MS_PER_S);
        end else begin
          mul_cmd.cycles = CNT_W'(G_MUL_CYCLES);
          mul_a          = MUL_A_W'(aerr);
          mul_b          = cfg.gain_p;
        end
      end
      ST_I_MUL: begin
        if (mul_done) begin
          div_cmd.start  = 1'b1;
          div_cmd.cycles = CNT_W'(I_DIV_CYCLES);
          div_dividend   = mul_prod[DIV_N_W+MS_W-1:MUL_B_W-I_MUL_CYCLES];
          div_divisor    = DIV_D_W'(MS_PER_S);
        end
      end
      ST_I_UPD: begin
        mul_cmd.start = 1'b1;
        if (deriv_go) begin
          mul_cmd.cycles = CNT_W'(D_MUL_CYCLES);
          mul_a          = MUL_A_W'(diff_mag);
          mul_b          = MUL_B_W'(MS_PER_S);
        end else begin
          mul_cmd.cycles = CNT_W'(G_MUL_CYCLES);
          mul_a          = MUL_A_W'(aerr);
          mul_b          = cfg.gain_p;
        end
      end
      ST_D_MUL: begin
        if (mul_done) begin
          // |diff| * 1000 fits D_DIV_CYCLES bits; load it MSB-aligned
          div_cmd.start  = 1'b1;
          div_cmd.cycles = CNT_W'(D_DIV_CYCLES);
          div_dividend   = {mul_prod[D_DIV_CYCLES+MUL_B_W-D_MUL_CYCLES-1:MUL_B_W-D_MUL_CYCLES],
                            {(DIV_N_W-D_DIV_CYCLES){1'b0}}};
          div_divisor    = in_q.elapsed_ms;
        end
      end
      ST_D_DIV: begin
        if (div_done) begin
          mul_cmd.start  = 1'b1;
          mul_cmd.cycles = CNT_W'(G_MUL_CYCLES);
          mul_a          = MUL_A_W'(aerr);
          mul_b          = cfg.gain_p;
        end
      end
      ST_P_MUL: begin
        if (mul_done) begin
          mul_cmd.start  = 1'b1;
          mul_cmd.cycles = CNT_W'(G_MUL_CYCLES);
          mul_a          = MUL_A_W'(integ_mag);
          mul_b          = cfg.gain_i;
        end
      end
      ST_G_MUL: begin
        if (mul_done && deriv_go) begin
          // derivative magnitude is still held in the divider
          mul_cmd.start  = 1'b1;
          mul_cmd.cycles = CNT_W'(G_MUL_CYCLES);
          mul_a          = MUL_A_W'(div_quot[D_DIV_CYCLES-1:0]);
          mul_b          = cfg.gain_d;
        end
      end
      default: ;
    endcase
  end

  // control and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      deriv_go    <= 1'b0;
      integral    <= '0;
      prev_target <= '0;
      prev_meas   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_SETUP) begin
        prev_target <= in_q.target;
        prev_meas   <= in_q.measured;
        if (in_q.target != prev_target) integral <= '0;
      end
      if (state == ST_FLAGS) begin
        deriv_go <= deriv_now_c;
        if (band_clear_c) integral <= '0;
      end
      if (state == ST_I_UPD) integral <= integ_sat;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_accept) in_q <= in_data;
    if (state == ST_SETUP) begin
      err  <= {in_q.target[DATA_W-1], in_q.target} - {in_q.measured[DATA_W-1], in_q.measured};
      diff <= {in_q.measured[DATA_W-1], in_q.measured} - {prev_meas[DATA_W-1], prev_meas};
    end
    if (state == ST_ABS) begin
      aerr     <= err_abs[DATA_W-1:0];
      diff_mag <= diff_abs[DATA_W-1:0];
      tgt_mag  <= tgt_abs;
    end
    if (mul_done && (state == ST_P_MUL || state == ST_G_MUL || state == ST_K_MUL)) begin
      acc <= acc_next;
    end
    if (state == ST_OUT && out_free) out_data <= out_result;
  end

endmodule

### design/pbic_checker.sv
// Port-level checks for the banded-integral PID controller, bound to the top level.
// Depends on pbic_pkg for the output struct and the drive limit.
module pbic_checker
  import pbic_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input pbic_out_t out_data
);

  localparam logic signed [DRIVE_W-1:0] DRIVE_LIM_S = DRIVE_W'(DRIVE_LIM);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // one transaction in flight: input closes right after an accept
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction is in flight");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.drive <= DRIVE_LIM_S) && (out_data.drive >= -DRIVE_LIM_S))
    else $error("drive beyond 127.0");

  a_clamp_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clamped |->
      (out_data.drive == DRIVE_LIM_S) || (out_data.drive == -DRIVE_LIM_S))
    else $error("clamped result not on a rail");

endmodule

bind pid_banded_integral_controller_top pbic_checker u_pbic_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### test/tb_pid_banded_integral_controller_top.sv
// Self-checking testbench for pid_banded_integral_controller_top: a table of directed
// steps, then randomized register settings and step sequences, checked by a predictor or table values.
// Depends on pbic_pkg and the design sources.
module tb_pid_banded_integral_controller_top;
  import pbic_pkg::*;

  localparam int NUM_REGS = 7;
  localparam logic [CFG_IDX_W-1:0] REG_STRAY = 3'd7;  // no register behind this index
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 155;
  localparam int PRESSURE_AT = 300;
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam longint SUM_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_BOT = -SUM_TOP - 1;

  typedef logic [NUM_REGS-1:0][CFG_DATA_W-1:0] reg_image_t;

  typedef struct {
    bit         load;
    reg_image_t image;
    pbic_in_t   item;
    bit         typed;
    pbic_out_t  want;
  } step_row_t;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_SPARSE} flow_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pbic_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pbic_out_t             out_data;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // controller mirror: registers and loop state
  logic [GAIN_W-1:0] kp = '0, ki = '0, kd = '0;
  longint band_lo = 0, band_hi = 0, gate_nr = 0, gate_fr = 0;
  longint integ = 0, last_meas = 0, last_tgt = 0;

  pbic_out_t drive_q[$];
  step_row_t steps[$];
  pbic_out_t want_now;
  int mismatches = 0, checked = 0, taken_in = 0, loads = 0;
  int gap_due = 0, burst_left = 1;
  int quiet = 0;
  flow_e flow = FLOW_FREE;
  int seg_left = 0, hold_left = 0;
  bit pressure_done = 1'b0;

  pid_banded_integral_controller_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d", checked, what, got, want);
    mismatches++;
  endtask

  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_GAIN_P:    kp = v;
      REG_GAIN_I:    ki = v;
      REG_GAIN_D:    kd = v;
      REG_BAND_LOW:  band_lo = v[BAND_W-1:0];
      REG_BAND_HIGH: band_hi = v[BAND_W-1:0];
      REG_GATE_NEAR: gate_nr = v[BAND_W-1:0];
      REG_GATE_FAR:  gate_fr = v[BAND_W-1:0];
      default: ;
    endcase
  endfunction

  // exact Q32.32 product of a signed value and an unsigned gain
  function automatic logic signed [127:0] gain_term(longint v, logic [GAIN_W-1:0] g);
    logic signed [127:0] a, b;
    a = v;
    b = g;
    return a * b;
  endfunction

  function automatic pbic_out_t step_drive(pbic_in_t d);
    longint tgt, meas, ms, err, aerr, rate, slack, sum;
    bit use_rate;
    logic signed [127:0] acc, lim;
    pbic_out_t r;
    tgt = $signed(d.target);
    meas = $signed(d.measured);
    ms = d.elapsed_ms;
    if (tgt != last_tgt) begin
      integ = 0;
      last_tgt = tgt;
    end
    rate = 0;
    if (ms > 0) rate = (meas - last_meas) * MS_PER_S / ms;
    last_meas = meas;
    err = tgt - meas;
    aerr = (err < 0) ? -err : err;
    // integrate only strictly inside the band, clear strictly above it
    if (aerr > band_lo && aerr < band_hi) begin
      sum = integ + err * ms / MS_PER_S;
      integ = (sum > SUM_TOP) ? SUM_TOP : (sum < SUM_BOT) ? SUM_BOT : sum;
    end
    if (aerr > band_hi) integ = 0;
    slack = ((tgt < 0) ? -tgt : tgt) - aerr;
    use_rate = (slack > 0 && aerr < gate_nr) || (slack < 0 && aerr < gate_fr);
    acc = gain_term(err, kp) + gain_term(integ, ki);
    if (use_rate) acc = acc - gain_term(rate, kd);
    lim = LIMIT_WHOLE;
    lim = lim <<< 32;
    r.clamped = 1'b1;
    if (acc > lim) begin
      r.drive = DRIVE_W'(DRIVE_LIM);
    end else if (acc < -lim) begin
      r.drive = DRIVE_W'(-DRIVE_LIM);
    end else begin
      r.drive = acc[FRAC_W +: DRIVE_W];
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  function automatic reg_image_t make_image(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                                            logic [31:0] bl, logic [31:0] bh,
                                            logic [31:0] gn, logic [31:0] gf);
    reg_image_t img;
    img[REG_GAIN_P] = p;
    img[REG_GAIN_I] = i;
    img[REG_GAIN_D] = d;
    img[REG_BAND_LOW] = bl;
    img[REG_BAND_HIGH] = bh;
    img[REG_GATE_NEAR] = gn;
    img[REG_GATE_FAR] = gf;
    return img;
  endfunction

  function automatic reg_image_t phase_image(int ph);
    logic [31:0] bl;
    bl = $urandom_range(32'h4_0000);
    case (ph)
      1: return make_image('1, '1, '1, '1, '1, '1, '1);  // band writes carry bit 31
      2: return make_image('0, '0, '0, '0, '0, '0, '0);
      3: return make_image($urandom_range(32'h400, 32'h4_0000), $urandom_range(32'h800),
                           $urandom_range(32'h400), '0, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF);
      4: return make_image($urandom_range(32'h400, 32'h4_0000), $urandom_range(32'h800),
                           $urandom_range(32'h400), 32'h40_0000, 32'h1_0000, '0, '0);
      5: return make_image($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom());
      7: return make_image('1, '0, 32'h1, $urandom() | 32'h8000_0000,
                           $urandom() | 32'h8000_0000, $urandom(), $urandom());
      default: return make_image($urandom_range(32'h400, 32'h4_0000), $urandom_range(32'h800),
                                 $urandom_range(32'h400), bl,
                                 bl + $urandom_range(32'h1_0000, 32'h80_0000),
                                 $urandom_range(32'h100_0000), $urandom_range(32'h100_0000));
    endcase
  endfunction

  function automatic void add_load(reg_image_t img);
    step_row_t row;
    row = '{load: 1'b1, image: img, item: '0, typed: 1'b0, want: '0};
    steps.push_back(row);
  endfunction

  function automatic void add_item(logic [31:0] t, logic [31:0] m, logic [15:0] ms,
                                   bit typed = 1'b0, logic [23:0] drv = '0, bit clp = 1'b0);
    step_row_t row;
    row.load = 1'b0;
    row.image = '0;
    row.item.target = t;
    row.item.measured = m;
    row.item.elapsed_ms = ms;
    row.typed = typed;
    row.want.drive = drv;
    row.want.clamped = clp;
    steps.push_back(row);
  endfunction

  // registers change only with the pipeline drained
  task automatic program_regs(reg_image_t img);
    logic [CFG_DATA_W-1:0] junk;
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_wen <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data <= img[r];
      store_reg(CFG_IDX_W'(r), img[r]);
      @(posedge clk);
    end
    junk = $urandom();
    cfg_wen <= 1'b1;
    cfg_index <= REG_STRAY;
    cfg_data <= junk;
    store_reg(REG_STRAY, junk);
    @(posedge clk);
    cfg_wen <= 1'b0;
    loads++;
  endtask

  // offer one step; the gap chosen after the previous transaction is taken first
  task automatic offer(pbic_in_t d, bit typed, pbic_out_t want);
    pbic_out_t calc;
    if (gap_due > 0) begin
      in_valid <= 1'b0;
      repeat (gap_due) @(posedge clk);
      gap_due = 0;
    end
    in_data <= d;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    calc = step_drive(d);
    drive_q.push_back(typed ? want : calc);
    taken_in++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
      gap_due = $urandom_range(1, 25);
    end
  endtask

  // receiver: compare each result, stall on a pattern, one long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        report_mismatch("result with no step pending", out_data.drive, 0);
      end else begin
        want_now = drive_q.pop_front();
        if (out_data.drive !== want_now.drive)
          report_mismatch("drive", out_data.drive, want_now.drive);
        if (out_data.clamped !== want_now.clamped)
          report_mismatch("clamped", out_data.clamped, want_now.clamped);
        checked++;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!pressure_done && taken_in >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        flow = flow_e'($urandom_range(3));
        seg_left = $urandom_range(16, 200);
      end
      seg_left--;
      case (flow)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(3) == 0);
        FLOW_HEAVY: out_stall <= ($urandom_range(3) != 0);
        default:    out_stall <= ($urandom_range(7) == 0);
      endcase
    end
  end

  initial begin
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: %0d cycles without a transaction", quiet);
    $display("tb_pid_banded_integral_controller_top NOT OK");
    $finish;
  end

  initial begin
    int run_len, span, off, sent, rand_steps;
    bit noisy;
    logic [31:0] tgt, meas;
    logic [15:0] ms;
    pbic_in_t item;
    pbic_out_t none;
    rand_steps = 0;
    none = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset: every gain is zero
    add_item(32'h0000_0000, 32'h0000_0000, 16'd0, 1'b1, 24'h000000, 1'b0);
    add_item(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b1, 24'h000000, 1'b0);
    add_item(32'h8000_0000, 32'h7FFF_FFFF, 16'd1, 1'b1, 24'h000000, 1'b0);
    // kp 1.0, ki 0.5, kd 0.25, band 1.0..10.0, gates 5.0 / 20.0
    add_load(make_image(32'h1_0000, 32'h8000, 32'h4000, 32'h1_0000, 32'hA_0000,
                        32'h5_0000, 32'h14_0000));
    add_item(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b1, 24'h7F0000, 1'b1);
    add_item(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 24'h810000, 1'b1);
    add_item(32'h0032_0000, 32'h0030_0000, 16'd10);
    add_item(32'h0032_0000, 32'h002F_0000, 16'd20);
    add_item(32'h0032_0000, 32'h0031_0000, 16'd10);  // error on the lower band
    add_item(32'h0032_0000, 32'h0028_0000, 16'd10);  // error on the upper band
    add_item(32'h0032_0000, 32'h002E_0000, 16'd0);   // no time elapsed
    add_item(32'h0032_0000, 32'h0027_0000, 16'd10);  // above band: integral cleared
    add_item(32'h0003_0000, 32'h0000_0000, 16'd5);   // |target| equals |error|
    add_item(32'h0003_0000, 32'h0006_0000, 16'd5);
    add_item(32'h0003_0000, 32'h0002_0000, 16'd5);
    add_item(32'h0003_0000, 32'h0009_0000, 16'd3);
    add_item(32'hFFEC_0000, 32'hFFED_8000, 16'd1);
    add_item(32'hFFEC_0000, 32'hFFE2_0000, 16'hFFFF);
    add_item(32'h0000_0000, 32'h0000_0000, 16'd0);
    add_load(make_image('1, '1, '1, '1, '1, '1, '1));
    add_item(32'h0000_0000, 32'h0000_0000, 16'd5, 1'b1, 24'h000000, 1'b0);
    add_item(32'h0000_0001, 32'h0000_0000, 16'd1);
    add_item(32'h7FFF_FFFF, 32'h7FFF_FFFE, 16'd1);
    add_item(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);

    foreach (steps[i]) begin
      if (steps[i].load) program_regs(steps[i].image);
      else offer(steps[i].item, steps[i].typed, steps[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      program_regs(phase_image(ph));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // mostly runs at a held setpoint so the integral builds up; some noise
        noisy = ($urandom_range(9) >= 7);
        if (noisy) begin
          run_len = $urandom_range(1, 4);
        end else begin
          run_len = $urandom_range(3, 40);
          tgt = ($urandom_range(3) == 0) ? $urandom()
              : 32'($urandom_range(32'h01FF_FFFF)) - 32'h0100_0000;
          case ($urandom_range(3))
            0: span = 32'h200;
            1: span = 32'h2_0000;
            2: span = 32'h20_0000;
            default: span = 32'h400_0000;
          endcase
        end
        for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
          if (noisy) begin
            item.target = $urandom();
            item.measured = $urandom();
            item.elapsed_ms = 16'($urandom());
          end else begin
            off = int'($urandom_range(2 * span)) - span;
            meas = tgt - off;
            if ($urandom_range(9) == 0) begin
              case ($urandom_range(5))
                0: meas = tgt - 32'(band_lo);
                1: meas = tgt + 32'(band_lo);
                2: meas = tgt - 32'(band_hi);
                3: meas = tgt + 32'(band_hi);
                4: meas = '0;
                default: meas = tgt << 1;
              endcase
            end
            case ($urandom_range(11))
              0: ms = '0;
              1: ms = 16'($urandom());
              default: ms = 16'($urandom_range(1, 50));
            endcase
            item.target = tgt;
            item.measured = meas;
            item.elapsed_ms = ms;
          end
          offer(item, 1'b0, none);
          sent++;
          rand_steps++;
        end
      end
    end

    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d table steps and %0d random steps over %0d register loads",
             steps.size() - 2, rand_steps, loads);
    $display("compared %0d results, %0d mismatches, %0d still pending",
             checked, mismatches, drive_q.size());
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("tb_pid_banded_integral_controller_top OK");
    end else begin
      $display("tb_pid_banded_integral_controller_top NOT OK");
    end
    $finish;
  end

endmodule

### pid_banded_integral_controller_top.f
design/pbic_pkg.sv
design/pbic_cfg_regs.sv
design/pbic_serial_mul.sv
design/pbic_serial_div.sv
design/pid_banded_integral_controller_top.sv
design/pbic_checker.sv
test/tb_pid_banded_integral_controller_top.sv
